/* rtl/mrk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrk_pkg
// Shared types, sizes and SHA-256 constants for the merkle root engine.
// ----------------------------------------------------------------------------
package mrk_pkg;

  localparam int MaxLevels = 32;
  localparam int LvlW      = $clog2(MaxLevels + 1);
  localparam int IdxW      = $clog2(MaxLevels);
  localparam int HashW     = 256;
  localparam int BlockW    = 512;

  localparam logic [HashW-1:0] ShaIv = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic             last;
    logic [HashW-1:0] hash;
  } leaf_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_FOLD,
    ST_OUT
  } seq_state_e;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

/* rtl/mrk_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrk_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mrk_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrk_fifo
// Two-entry leaf request queue between the input port and the tree sequencer.
// ----------------------------------------------------------------------------
module mrk_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mrk_pkg::leaf_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mrk_pkg::leaf_t pop_data_o
);
  import mrk_pkg::*;

  leaf_t       mem_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_push, do_pop;

  assign full_o     = cnt_q[1];
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !cnt_q[1];
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/mrk_sha.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrk_sha
// SHA-256 compression unit, one round per cycle, 64 rounds per block.
// ----------------------------------------------------------------------------
module mrk_sha (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mrk_pkg::HashW-1:0]       init_i,
  input  logic [mrk_pkg::BlockW-1:0]      block_i,
  output logic                            done_o,
  output logic [mrk_pkg::HashW-1:0]       digest_o
);
  import mrk_pkg::*;

  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [31:0] iv_q [8];
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [31:0] s0, s1, e1, a0, ch, mj, t1, t2, wn;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    e1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + e1 + ch + round_k(cnt_q) + w_q[0];
    a0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = a0 + mj;
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wn = w_q[0] + s0 + w_q[9] + s1;
    v_d    = v_q;
    w_d    = w_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      for (int i = 0; i < 8; i++) begin
        v_d[i] = init_i[HashW-1-32*i -: 32];
      end
      for (int i = 0; i < 16; i++) begin
        w_d[i] = block_i[BlockW-1-32*i -: 32];
      end
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = wn;
      cnt_d   = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      digest_o[HashW-1-32*i -: 32] = iv_q[i] + v_q[i];
    end
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    w_q   <= w_d;
    if (start_i) begin
      for (int i = 0; i < 8; i++) begin
        iv_q[i] <= init_i[HashW-1-32*i -: 32];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 6'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

endmodule

/* rtl/mrk_tree.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrk_tree
// Tree sequencer: carries leaves up the level stack and folds out the root.
// ----------------------------------------------------------------------------
module mrk_tree (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      leaf_valid_i,
  input  mrk_pkg::leaf_t            leaf_i,
  output logic                      leaf_pop_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic [mrk_pkg::HashW-1:0] res_hash_o,
  output logic                      res_flag_o
);
  import mrk_pkg::*;

  localparam logic [BlockW-HashW-1:0] PadHash = {32'h80000000, 192'b0, 32'h00000100};
  localparam logic [BlockW-1:0]       PadBlk  = {32'h80000000, 448'b0, 32'h00000200};
  localparam logic [LvlW-1:0]         LvlMax  = LvlW'(MaxLevels);

  seq_state_e           state_q, state_d;
  logic [HashW-1:0]     h_q, h_d, res_h_q, res_h_d;
  logic [LvlW-1:0]      lvl_q, lvl_d;
  logic                 last_q, last_d, fin_q, fin_d, ovf_q, ovf_d;
  logic                 res_f_q, res_f_d, rv_q, rv_d;
  logic [MaxLevels-1:0] occ_q, occ_d, above;
  logic [IdxW-1:0]      idx;
  logic                 lvl_in, hit, higher;
  logic                 ram_we;
  logic [HashW-1:0]     ram_rdata, digest;
  logic [HashW-1:0]     core_init;
  logic [BlockW-1:0]    core_blk;
  logic                 core_start, core_done;

  assign idx    = lvl_q[IdxW-1:0];
  assign lvl_in = (lvl_q < LvlMax);
  assign hit    = lvl_in && occ_q[idx];

  always_comb begin
    for (int i = 0; i < MaxLevels; i++) begin
      above[i] = (LvlW'(i) > lvl_q);
    end
    higher = |(occ_q & above);
  end

  mrk_ram #(
    .Width(HashW),
    .Depth(MaxLevels)
  ) u_stack (
    .clk_i,
    .we_i   (ram_we),
    .waddr_i(idx),
    .wdata_i(h_q),
    .raddr_i(idx),
    .rdata_o(ram_rdata)
  );

  mrk_sha u_sha (
    .clk_i,
    .rst_ni,
    .start_i (core_start),
    .init_i  (core_init),
    .block_i (core_blk),
    .done_o  (core_done),
    .digest_o(digest)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (leaf_valid_i) state_d = ST_CHECK;
      ST_CHECK: begin
        if (hit) state_d = ST_READ;
        else if (fin_q) state_d = ST_FOLD;
        else if (!last_q) state_d = ST_IDLE;
        else if (ovf_q || !lvl_in) state_d = ST_OUT;
        else state_d = ST_FOLD;
      end
      ST_READ:  state_d = ST_H1;
      ST_H1:    if (core_done) state_d = ST_H2;
      ST_H2:    if (core_done) state_d = ST_H3;
      ST_H3:    if (core_done) state_d = ST_CHECK;
      ST_FOLD:  state_d = higher ? ST_H1 : ST_OUT;
      ST_OUT:   if (!rv_q || res_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    h_d        = h_q;
    res_h_d    = res_h_q;
    res_f_d    = res_f_q;
    lvl_d      = lvl_q;
    last_d     = last_q;
    fin_d      = fin_q;
    ovf_d      = ovf_q;
    occ_d      = occ_q;
    rv_d       = rv_q && !res_ready_i;
    leaf_pop_o = 1'b0;
    ram_we     = 1'b0;
    core_start = 1'b0;
    core_init  = ShaIv;
    core_blk   = {h_q, h_q};
    unique case (state_q)
      ST_IDLE: begin
        if (leaf_valid_i) begin
          leaf_pop_o = 1'b1;
          h_d        = leaf_i.hash;
          last_d     = leaf_i.last;
          lvl_d      = '0;
          fin_d      = 1'b0;
        end
      end
      ST_CHECK: begin
        if (!hit && !fin_q) begin
          if (lvl_in) begin
            ram_we     = 1'b1;
            occ_d[idx] = 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_q && !(ovf_q || !lvl_in)) begin
            occ_d[idx] = 1'b0;
            fin_d      = 1'b1;
          end
        end
      end
      ST_READ: begin
        core_start = 1'b1;
        core_blk   = {ram_rdata, h_q};
        occ_d[idx] = 1'b0;
        lvl_d      = lvl_q + 1'b1;
      end
      ST_H1: begin
        if (core_done) begin
          core_start = 1'b1;
          core_init  = digest;
          core_blk   = PadBlk;
        end
      end
      ST_H2: begin
        if (core_done) begin
          core_start = 1'b1;
          core_blk   = {digest, PadHash};
        end
      end
      ST_H3: begin
        if (core_done) h_d = digest;
      end
      ST_FOLD: begin
        if (higher) begin
          core_start = 1'b1;
          lvl_d      = lvl_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (!rv_q || res_ready_i) begin
          rv_d    = 1'b1;
          res_h_d = ovf_q ? '0 : h_q;
          res_f_d = ovf_q;
          occ_d   = '0;
          ovf_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o = rv_q;
  assign res_hash_o  = res_h_q;
  assign res_flag_o  = res_f_q;

  always_ff @(posedge clk_i) begin
    h_q     <= h_d;
    res_h_q <= res_h_d;
    res_f_q <= res_f_d;
    lvl_q   <= lvl_d;
    last_q  <= last_d;
    fin_q   <= fin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovf_q   <= 1'b0;
      occ_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
      occ_q   <= occ_d;
      rv_q    <= rv_d;
    end
  end

endmodule

/* rtl/merkle_root_double_sha256.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merkle_root_double_sha256
// Merkle root engine over double SHA-256 with a level stack in RAM.
// ----------------------------------------------------------------------------
// Leaves enter through a two-entry queue; a sequencer merges them into a stack
// of pending hashes, one per level. Each pair merge runs three 64-round
// compressions on one shared SHA-256 round unit to turn the stack entry and the
// incoming hash into the merged hash. A leaf holds the sequencer until all of
// its merges are done; the last leaf also folds the remaining levels, one
// double hash per step on the way up, before the root request appears on the
// master side.
module merkle_root_double_sha256 (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,  // leaf_word_0, leaf_word_1, leaf_word_2, leaf_word_3
  input  logic         s_axis_tlast,  // last_leaf
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata,  // root_word_0, root_word_1, root_word_2, root_word_3
  output logic         m_axis_tuser   // too_many_leaves
);
  import mrk_pkg::*;

  leaf_t            in_leaf, q_leaf;
  logic             q_full, q_valid, q_pop;
  logic [HashW-1:0] root;

  assign in_leaf.last = s_axis_tlast;
  assign in_leaf.hash = {s_axis_tdata[63:0], s_axis_tdata[127:64],
                         s_axis_tdata[191:128], s_axis_tdata[255:192]};
  assign s_axis_tready = !q_full;

  mrk_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i     (s_axis_tvalid),
    .push_data_i(in_leaf),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_leaf)
  );

  mrk_tree u_tree (
    .clk_i,
    .rst_ni,
    .leaf_valid_i(q_valid),
    .leaf_i      (q_leaf),
    .leaf_pop_o  (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_hash_o  (root),
    .res_flag_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {root[63:0], root[127:64], root[191:128], root[255:192]};

endmodule
